>>> sv/pidl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional insert/delete list.
// No dependencies; used by the controller, datapath, top level and checker.
package pidl_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int WIDTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int CNT_OUT_W = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_data;
    } t_req;

    typedef struct packed {
        logic                 accepted;
        logic [DATA_W-1:0]    result_data;
        logic [CNT_OUT_W-1:0] list_count;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CAPTURE,
        S_DEL_CHK,
        S_DEL_WR,
        S_INS_CHK,
        S_INS_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_POS,
        RD_IDX,
        RD_IDX_M1
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_POS,
        WR_IDX,
        WR_IDX_M1
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    decode;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    idx_ld_cnt;
        logic    idx_ld_pos;
        logic    idx_inc;
        logic    idx_dec;
        logic    cap;
        logic    cnt_inc;
        logic    cnt_dec;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [1:0] kind;
        logic       del_more;
        logic       ins_more;
    } t_stat;

endpackage

>>> sv/pidl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pidl_ram #(
    parameter int W = 32,
    parameter int D = 128
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pidl_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: sequences decode, RAM reads, entry shifts and result beat.
// Depends on pidl_pkg.
module pidl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pidl_pkg::t_stat i_stat,
    output pidl_pkg::t_cmd  o_cmd,
    output logic            o_done,
    output logic            o_busy
);
    import pidl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_POS;
        o_cmd.wr_sel = WR_POS;
        o_done  = 1'b0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (!i_stat.ok) begin
                    n_state = S_DONE;
                end else if (i_stat.kind == KIND_INSERT) begin
                    o_cmd.idx_ld_cnt = 1'b1;
                    n_state          = S_INS_CHK;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_POS;
                    n_state      = S_CAPTURE;
                end
            end
            S_CAPTURE: begin
                o_cmd.cap = 1'b1;
                if (i_stat.kind == KIND_READ) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_ld_pos = 1'b1;
                    n_state          = S_DEL_CHK;
                end
            end
            S_DEL_CHK: begin
                if (i_stat.del_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_DEL_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_IDX_M1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_CHK;
            end
            S_INS_CHK: begin
                if (i_stat.ins_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_POS;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_IDX;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_INS_CHK;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/pidl_dp.sv
`timescale 1ns / 1ps
// Datapath: request and count registers, shift index, entry RAM, result.
// Depends on pidl_pkg and pidl_ram.
module pidl_dp #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF,
    parameter int WIDTH = pidl_pkg::WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pidl_pkg::t_req  i_req,
    input  pidl_pkg::t_cmd  i_cmd,
    output pidl_pkg::t_stat o_stat,
    output pidl_pkg::t_res  o_res
);
    import pidl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int SW = (WIDTH < DATA_W) ? WIDTH : DATA_W;

    t_req          r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_acc;
    logic [SW-1:0] r_rdat;

    logic [MW-1:0] w_pos_e;
    logic [MW-1:0] w_cnt_e;
    logic [MW-1:0] w_idx_e;
    logic [MW-1:0] w_pos_m1;
    logic [CW-1:0] w_idx_m1;
    logic          w_ok;

    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [SW-1:0] w_wdata;
    logic [SW-1:0] w_rdata;

    assign w_pos_e  = MW'(r_req.position);
    assign w_cnt_e  = MW'(r_count);
    assign w_idx_e  = MW'(r_idx);
    assign w_pos_m1 = w_pos_e - MW'(1);
    assign w_idx_m1 = r_idx - CW'(1);

    always_comb begin
        w_ok = 1'b0;
        if (r_req.position != '0) begin
            case (r_req.kind)
                KIND_INSERT: w_ok = (w_pos_e <= w_cnt_e + MW'(1)) && (w_cnt_e < MW'(DEPTH));
                KIND_DELETE: w_ok = (w_pos_e <= w_cnt_e);
                KIND_READ:   w_ok = (w_pos_e <= w_cnt_e);
                default:     w_ok = 1'b0;
            endcase
        end
    end

    assign o_stat.ok       = w_ok;
    assign o_stat.kind     = r_req.kind;
    assign o_stat.del_more = (r_idx < r_count);
    assign o_stat.ins_more = (w_idx_e >= w_pos_e);

    always_comb begin
        w_re = i_cmd.rd_en;
        case (i_cmd.rd_sel)
            RD_POS:    w_raddr = w_pos_m1[AW-1:0];
            RD_IDX:    w_raddr = r_idx[AW-1:0];
            RD_IDX_M1: w_raddr = w_idx_m1[AW-1:0];
            default:   w_raddr = w_pos_m1[AW-1:0];
        endcase
    end

    always_comb begin
        w_we = i_cmd.wr_en;
        case (i_cmd.wr_sel)
            WR_POS: begin
                w_waddr = w_pos_m1[AW-1:0];
                w_wdata = r_req.item_data[SW-1:0];
            end
            WR_IDX: begin
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
            end
            WR_IDX_M1: begin
                w_waddr = w_idx_m1[AW-1:0];
                w_wdata = w_rdata;
            end
            default: begin
                w_waddr = w_pos_m1[AW-1:0];
                w_wdata = r_req.item_data[SW-1:0];
            end
        endcase
    end

    pidl_ram #(
        .W(SW),
        .D(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_rdat <= '0;
        end else if (i_cmd.cap) begin
            r_rdat <= w_rdata;
        end
        if (i_cmd.decode) begin
            r_acc <= w_ok;
        end
        if (i_cmd.idx_ld_cnt) begin
            r_idx <= r_count;
        end else if (i_cmd.idx_ld_pos) begin
            r_idx <= CW'(r_req.position);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= w_idx_m1;
        end
    end

    assign o_res.accepted    = r_acc;
    assign o_res.result_data = DATA_W'(r_rdat);
    assign o_res.list_count  = CNT_OUT_W'(r_count);

endmodule

>>> sv/positional_insert_delete_list_core.sv
`timescale 1ns / 1ps
// Top level of the positional insert/delete list: controller plus datapath.
// Depends on pidl_pkg, pidl_ctrl, pidl_dp.
//
// A request is taken when start is high and busy is low; busy then stays high
// until its result has been shown. Each result is on o_result for exactly one
// cycle with o_done high and must be captured then: the receiver cannot stall
// the block. Entries live in a single-port-read, single-port-write RAM, so the
// shift reads an entry in a check state and writes it in the next write state.
// A read steps via decode, capture, done; a delete via decode, capture,
// check/write pairs, done; an insert via decode, check/write pairs, done; a
// refused one via decode, done; idle comes before the next accept. Entries are
// undefined after reset; only the count is cleared: there is no clearing pass.
module positional_insert_delete_list_core #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF,
    parameter int WIDTH = pidl_pkg::WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  pidl_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output pidl_pkg::t_res o_result
);
    import pidl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pidl_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_done (o_done),
        .o_busy (busy)
    );

    pidl_dp #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_res  (o_result)
    );

endmodule

>>> sv/pidl_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the positional insert/delete list, bound to the top.
// Depends on pidl_pkg and positional_insert_delete_list_core.
module pidl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input pidl_pkg::t_res o_result
);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat while not busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted beat not followed by busy");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("busy held after result beat");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.accepted) |-> (o_result.result_data == '0))
        else $error("refused beat carries data");

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result)
);
